// File: src/rbd_pkg.sv
// shared types and constants for the rgba5551 box downsampler
package rbd_pkg;

  // pixel format
  localparam int PIX_W = 16;
  localparam int CHW   = 5;
  localparam logic [CHW-1:0] CH_MAX = 5'd31;

  // configuration register widths
  localparam int OW_W       = 7;
  localparam int OH_W       = 7;
  localparam int SW_W       = 4;
  localparam int SH_W       = 4;
  localparam int XO_W       = 9;
  localparam int YO_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET      = 3'd5;

  // where the current source pixel sits relative to the block grid
  typedef struct packed {
    logic in_win;     // inside the output window
    logic run_first;  // first column of a block
    logic col_done;   // last column of a block
    logic row_first;  // first row of a block
    logic row_done;   // last row of a block
    logic last;       // bottom-right block of the output image
  } loc_t;

endpackage

// File: src/rbd_ram.sv
// generic single-port-write, registered-read ram
module rbd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/rbd_locate.sv
// source position tracker with block-grid counters and a serial resync divider
module rbd_locate
  import rbd_pkg::*;
#(
  parameter int SCREEN_W   = 320,
  parameter int SCREEN_H   = 240,
  parameter int MAX_OUT_W  = 64,
  parameter int MAX_SAMPLE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [XO_W-1:0]                 x_offset,
  input  logic [YO_W-1:0]                 y_offset,
  input  logic [$clog2(MAX_SAMPLE+1)-1:0] sw_c,
  input  logic [$clog2(MAX_SAMPLE+1)-1:0] sh_c,
  input  logic [$clog2(MAX_OUT_W+1)-1:0]  ow_c,
  input  logic [OH_W-1:0]                 oh_c,
  input  logic                            step,
  input  logic                            frame_start,
  output logic                            ready,
  output loc_t                            loc,
  output logic [$clog2(MAX_OUT_W)-1:0]    ix_addr
);

  localparam int CW   = $clog2(SCREEN_W);
  localparam int RW   = $clog2(SCREEN_H);
  localparam int PW   = (CW > RW) ? CW : RW;
  localparam int SMB  = $clog2(MAX_SAMPLE+1);
  localparam int AW   = $clog2(MAX_OUT_W);
  localparam int CNTW = $clog2(PW+1);

  typedef enum logic [1:0] {
    ST_READY = 2'b01,
    ST_DIV   = 2'b10
  } rs_state_t;

  rs_state_t       state_r, state_nxt;
  logic            pend_r;
  logic [CNTW-1:0] cnt_r;

  logic [CW-1:0]  col_r, ix_r;
  logic [RW-1:0]  row_r, iy_r;
  logic           cin_r, rin_r;
  logic [SMB-1:0] sx_r, sy_r;

  logic [PW-1:0]  dvx_r, dvy_r, qx_r, qy_r;
  logic [SMB-1:0] remx_r, remy_r;

  // current item's view
  logic [CW-1:0]  c_col, c_ix;
  logic [RW-1:0]  c_row, c_iy;
  logic           c_cin, c_rin;
  logic [SMB-1:0] c_sx, c_sy;

  // position after this item
  logic [CW-1:0]  col_nxt, ix_nxt;
  logic [RW-1:0]  row_nxt, iy_nxt;
  logic           cin_nxt, rin_nxt;
  logic [SMB-1:0] sx_nxt, sy_nxt;
  logic           cwrap, rwrap;

  logic [SMB:0]   remx_t, remy_t;
  logic           gex, gey;

  always_comb begin
    if (frame_start) begin
      c_col = '0;
      c_row = '0;
      c_cin = (x_offset == '0);
      c_rin = (y_offset == '0);
      c_sx  = '0;
      c_sy  = '0;
      c_ix  = '0;
      c_iy  = '0;
    end else begin
      c_col = col_r;
      c_row = row_r;
      c_cin = cin_r;
      c_rin = rin_r;
      c_sx  = sx_r;
      c_sy  = sy_r;
      c_ix  = ix_r;
      c_iy  = iy_r;
    end
  end

  always_comb begin
    loc.in_win    = c_cin && c_rin && (c_ix < ow_c) && (c_iy < oh_c);
    loc.run_first = (c_sx == '0);
    loc.col_done  = (c_sx == SMB'(sw_c - 1'b1));
    loc.row_first = (c_sy == '0);
    loc.row_done  = (c_sy == SMB'(sh_c - 1'b1));
    loc.last      = (c_ix == ow_c - 1'b1) && (c_iy == oh_c - 1'b1);
    ix_addr       = AW'(c_ix);
  end

  // column then row advance
  always_comb begin
    cwrap   = (c_col == CW'(SCREEN_W - 1));
    col_nxt = cwrap ? '0 : CW'(c_col + 1'b1);
    cin_nxt = c_cin;
    sx_nxt  = c_sx;
    ix_nxt  = c_ix;
    if (col_nxt == x_offset) begin
      cin_nxt = 1'b1;
      sx_nxt  = '0;
      ix_nxt  = '0;
    end else if (cwrap) begin
      cin_nxt = 1'b0;
      sx_nxt  = '0;
      ix_nxt  = '0;
    end else if (c_cin) begin
      if (c_sx == SMB'(sw_c - 1'b1)) begin
        sx_nxt = '0;
        ix_nxt = CW'(c_ix + 1'b1);
      end else begin
        sx_nxt = SMB'(c_sx + 1'b1);
      end
    end

    rwrap   = (c_row == RW'(SCREEN_H - 1));
    row_nxt = c_row;
    rin_nxt = c_rin;
    sy_nxt  = c_sy;
    iy_nxt  = c_iy;
    if (cwrap) begin
      row_nxt = rwrap ? '0 : RW'(c_row + 1'b1);
      if (row_nxt == y_offset) begin
        rin_nxt = 1'b1;
        sy_nxt  = '0;
        iy_nxt  = '0;
      end else if (rwrap) begin
        rin_nxt = 1'b0;
        sy_nxt  = '0;
        iy_nxt  = '0;
      end else if (c_rin) begin
        if (c_sy == SMB'(sh_c - 1'b1)) begin
          sy_nxt = '0;
          iy_nxt = RW'(c_iy + 1'b1);
        end else begin
          sy_nxt = SMB'(c_sy + 1'b1);
        end
      end
    end
  end

  // restoring divide step, one quotient bit per cycle for both axes
  always_comb begin
    remx_t = {remx_r, dvx_r[PW-1]};
    remy_t = {remy_r, dvy_r[PW-1]};
    gex    = (remx_t >= {1'b0, sw_c});
    gey    = (remy_t >= {1'b0, sh_c});
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_READY: if (pend_r) state_nxt = ST_DIV;
      ST_DIV:   if (!pend_r && cnt_r == '0) state_nxt = ST_READY;
      default:  state_nxt = ST_READY;
    endcase
  end

  assign ready = (state_r == ST_READY) && !pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_READY;
      pend_r  <= 1'b1;
      cnt_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      cin_r   <= 1'b0;
      rin_r   <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
      ix_r    <= '0;
      iy_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= cfg_we;
      if (pend_r) begin
        cnt_r <= CNTW'(PW);
        cin_r <= (col_r >= x_offset);
        rin_r <= (row_r >= y_offset);
      end else if (state_r == ST_DIV) begin
        if (cnt_r == '0) begin
          ix_r <= CW'(qx_r);
          iy_r <= RW'(qy_r);
          sx_r <= remx_r;
          sy_r <= remy_r;
        end else begin
          cnt_r <= CNTW'(cnt_r - 1'b1);
        end
      end else if (step) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        cin_r <= cin_nxt;
        rin_r <= rin_nxt;
        sx_r  <= sx_nxt;
        sy_r  <= sy_nxt;
        ix_r  <= ix_nxt;
        iy_r  <= iy_nxt;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (pend_r) begin
      dvx_r  <= (col_r >= x_offset) ? PW'(col_r - x_offset) : '0;
      dvy_r  <= (row_r >= y_offset) ? PW'(row_r - y_offset) : '0;
      remx_r <= '0;
      remy_r <= '0;
      qx_r   <= '0;
      qy_r   <= '0;
    end else if (state_r == ST_DIV && cnt_r != '0) begin
      dvx_r  <= {dvx_r[PW-2:0], 1'b0};
      dvy_r  <= {dvy_r[PW-2:0], 1'b0};
      remx_r <= gex ? SMB'(remx_t - {1'b0, sw_c}) : SMB'(remx_t);
      remy_r <= gey ? SMB'(remy_t - {1'b0, sh_c}) : SMB'(remy_t);
      qx_r   <= {qx_r[PW-2:0], gex};
      qy_r   <= {qy_r[PW-2:0], gey};
    end
  end

endmodule

// File: src/rbd_avg.sv
// block average: rounded divide by pixel count via reciprocal multiply, two stages
module rbd_avg
  import rbd_pkg::*;
#(
  parameter int MAX_SAMPLE = 8
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    en,
  input  logic                                                    in_v,
  input  logic [2:0][$clog2(((2**CHW)-1)*MAX_SAMPLE*MAX_SAMPLE+1)-1:0] sums,
  input  logic [$clog2(MAX_SAMPLE*MAX_SAMPLE+1)-1:0]              n,
  input  logic                                                    in_last,
  output logic                                                    out_v,
  output logic [PIX_W-1:0]                                        out_pixel,
  output logic                                                    out_last
);

  localparam int NMAX = MAX_SAMPLE * MAX_SAMPLE;
  // x = 2*sum + n stays at or below (2*31+1)*n
  localparam int XW   = $clog2(((2**(CHW+1))-1)*NMAX+1);
  localparam int DW   = $clog2(2*NMAX+1);
  localparam int K    = XW + DW;
  localparam int PRW  = XW + K;

  logic [K-1:0] recip [NMAX+1];

  genvar gi;
  generate
    for (gi = 0; gi <= NMAX; gi++) begin : g_rc
      if (gi == 0) begin : g_zero
        assign recip[gi] = '0;
      end else begin : g_val
        localparam longint unsigned RC =
          ((longint'(1) << K) + 2*gi - 1) / (2*gi);
        assign recip[gi] = K'(RC);
      end
    end
  endgenerate

  logic                  a_v_r, b_v_r;
  logic                  a_last_r, b_last_r;
  logic [2:0][XW-1:0]    a_x_r;
  logic [K-1:0]          a_m_r;
  logic [2:0][PRW-1:0]   b_p_r;
  logic [2:0][CHW-1:0]   q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_x_r[k] <= XW'({sums[k], 1'b0}) + XW'(n);
        b_p_r[k] <= PRW'(a_x_r[k]) * PRW'(a_m_r);
      end
      a_m_r    <= recip[n];
      a_last_r <= in_last;
      b_last_r <= a_last_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q[k] = (b_p_r[k][PRW-1:K] > XW'(CH_MAX)) ? CH_MAX : CHW'(b_p_r[k][PRW-1:K]);
    end
  end

  assign out_v     = b_v_r;
  assign out_pixel = {q[0], q[1], q[2], 1'b1};
  assign out_last  = b_last_r;

endmodule

// File: src/rgb5551_box_downsample_unit.sv
// top level of the rgba5551 box-filter downsampler
//
//  port group | dir | payload                              | handshake
//  -----------+-----+--------------------------------------+------------------
//  in_        | in  | tdata: pixel[15:0]; tuser: frame_start | tvalid / tready
//  out_       | out | tdata: avg_pixel[15:0]; tlast: last  | tvalid / tready
//  cfg_       | in  | idx 0..5, wdata up to 9 bits         | we, no wait state
//
// one source pixel per clock while in_tready is high; the single column-sum ram is read
//   when a run closes in the window and is written back by the read-modify-write stage,
//   forwarding covers back-to-back hits; a result passes that stage and both averaging stages
//   into the output register; after reset and after every cfg write the block-grid counters
//   are rebuilt from the source position by a serial divider, in_tready low
// sync active-low reset; a stalled output first fills a one-entry skid, then stalls input
module rgb5551_box_downsample_unit
  import rbd_pkg::*;
#(
  parameter int SCREEN_W   = 320,
  parameter int SCREEN_H   = 240,
  parameter int MAX_OUT_W  = 64,
  parameter int MAX_SAMPLE = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // pixel[15:0]
  input  logic                  in_tuser,   // frame_start
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // avg_pixel[15:0]
  output logic                  out_tlast,  // last_of_image
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NMAX = MAX_SAMPLE * MAX_SAMPLE;
  localparam int SMB  = $clog2(MAX_SAMPLE+1);
  localparam int OWB  = $clog2(MAX_OUT_W+1);
  localparam int AW   = $clog2(MAX_OUT_W);
  localparam int NB   = $clog2(NMAX+1);
  // one channel sum of a full block
  localparam int FW   = $clog2(((2**CHW)-1)*NMAX+1);

  // configuration registers
  logic [OW_W-1:0] ow_r;
  logic [OH_W-1:0] oh_r;
  logic [SW_W-1:0] sw_r;
  logic [SH_W-1:0] sh_r;
  logic [XO_W-1:0] xo_r;
  logic [YO_W-1:0] yo_r;

  // saturated sizes
  logic [SMB-1:0]  sw_c, sh_c;
  logic [OWB-1:0]  ow_c;
  logic [OH_W-1:0] oh_c;
  logic [NB-1:0]   n_c;

  // handshake and location
  logic            adv, accept, loc_ready, rd_en;
  loc_t            loc;
  logic [AW-1:0]   ix_addr;

  // per-block-row running sum along the current row
  logic [2:0][CHW-1:0] ch;
  logic [2:0][FW-1:0]  run_r, run_nxt;

  // read-modify-write stage
  logic                s1_v_r, s1_first_r, s1_emit_r, s1_last_r, s1_fwd_r, s1_seen_r;
  logic [AW-1:0]       s1_addr_r;
  logic [2:0][FW-1:0]  s1_run_r, fw_r;
  logic [2:0][FW-1:0]  mem_rdata, old_sum, new_sum;
  logic                mem_we;
  logic [MAX_OUT_W-1:0] wr_seen_r;

  // result side
  logic                res_v, res_last;
  logic [PIX_W-1:0]    res_pix;
  logic                out_v_r, out_last_r, skid_v_r, skid_last_r, out_take;
  logic [PIX_W-1:0]    out_pix_r, skid_pix_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ow_r <= OW_W'(40);
      oh_r <= OH_W'(40);
      sw_r <= SW_W'(2);
      sh_r <= SH_W'(2);
      xo_r <= XO_W'(120);
      yo_r <= YO_W'(80);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OUT_WIDTH:     ow_r <= cfg_wdata[OW_W-1:0];
        REG_OUT_HEIGHT:    oh_r <= cfg_wdata[OH_W-1:0];
        REG_SAMPLE_WIDTH:  sw_r <= cfg_wdata[SW_W-1:0];
        REG_SAMPLE_HEIGHT: sh_r <= cfg_wdata[SH_W-1:0];
        REG_X_OFFSET:      xo_r <= cfg_wdata[XO_W-1:0];
        REG_Y_OFFSET:      yo_r <= cfg_wdata[YO_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range sizes saturate
  always_comb begin
    if (sw_r == '0)                    sw_c = SMB'(1);
    else if (32'(sw_r) > MAX_SAMPLE)   sw_c = SMB'(MAX_SAMPLE);
    else                               sw_c = SMB'(sw_r);
    if (sh_r == '0)                    sh_c = SMB'(1);
    else if (32'(sh_r) > MAX_SAMPLE)   sh_c = SMB'(MAX_SAMPLE);
    else                               sh_c = SMB'(sh_r);
    if (ow_r == '0)                    ow_c = OWB'(1);
    else if (32'(ow_r) > MAX_OUT_W)    ow_c = OWB'(MAX_OUT_W);
    else                               ow_c = OWB'(ow_r);
    oh_c = (oh_r == '0) ? OH_W'(1) : oh_r;
    n_c  = NB'(sw_c) * NB'(sh_c);
  end

  // the skid must be free so that whatever is in flight has somewhere to land
  assign adv       = !skid_v_r;
  assign in_tready = loc_ready && adv;
  assign accept    = in_tvalid && in_tready;

  rbd_locate #(
    .SCREEN_W  (SCREEN_W),
    .SCREEN_H  (SCREEN_H),
    .MAX_OUT_W (MAX_OUT_W),
    .MAX_SAMPLE(MAX_SAMPLE)
  ) u_locate (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .x_offset   (xo_r),
    .y_offset   (yo_r),
    .sw_c       (sw_c),
    .sh_c       (sh_c),
    .ow_c       (ow_c),
    .oh_c       (oh_c),
    .step       (accept),
    .frame_start(in_tuser),
    .ready      (loc_ready),
    .loc        (loc),
    .ix_addr    (ix_addr)
  );

  // red, green, blue
  assign ch[0] = in_tdata[15:11];
  assign ch[1] = in_tdata[10:6];
  assign ch[2] = in_tdata[5:1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      run_nxt[k] = loc.run_first ? FW'(ch[k]) : FW'(run_r[k] + FW'(ch[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (accept && loc.in_win) begin
      run_r <= run_nxt;
    end
  end

  // a block row's column sum is fetched only when a run along the row closes
  assign rd_en = accept && loc.in_win && loc.col_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r  <= ix_addr;
      s1_run_r   <= run_nxt;
      s1_first_r <= loc.row_first;
      s1_emit_r  <= loc.row_done;
      s1_last_r  <= loc.last;
      s1_seen_r  <= wr_seen_r[ix_addr];
      // the ram returns old data when the item ahead writes the same column this edge
      s1_fwd_r   <= s1_v_r && (s1_addr_r == ix_addr);
    end
    if (mem_we) begin
      fw_r <= new_sum;
    end
  end

  // columns never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_seen_r <= '0;
    end else if (mem_we) begin
      wr_seen_r[s1_addr_r] <= 1'b1;
    end
  end

  assign old_sum = s1_fwd_r ? fw_r : (s1_seen_r ? mem_rdata : '0);

  // first row of a block overwrites, so stale sums never need clearing
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      new_sum[k] = s1_first_r ? s1_run_r[k] : FW'(old_sum[k] + s1_run_r[k]);
    end
  end

  assign mem_we = s1_v_r && adv;

  rbd_ram #(
    .W(3*FW),
    .D(MAX_OUT_W)
  ) u_colsum (
    .clk  (clk),
    .we   (mem_we),
    .waddr(s1_addr_r),
    .wdata(new_sum),
    .re   (rd_en),
    .raddr(ix_addr),
    .rdata(mem_rdata)
  );

  rbd_avg #(
    .MAX_SAMPLE(MAX_SAMPLE)
  ) u_avg (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (s1_v_r && s1_emit_r),
    .sums     (new_sum),
    .n        (n_c),
    .in_last  (s1_last_r),
    .out_v    (res_v),
    .out_pixel(res_pix),
    .out_last (res_last)
  );

  // output register with one skid entry behind it
  assign out_take = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (adv && res_v) begin
      if (!out_v_r || out_take) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r  <= skid_v_r;
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_v) begin
      if (!out_v_r || out_take) begin
        out_pix_r  <= res_pix;
        out_last_r <= res_last;
      end else begin
        skid_pix_r  <= res_pix;
        skid_last_r <= res_last;
      end
    end else if (out_take) begin
      out_pix_r  <= skid_pix_r;
      out_last_r <= skid_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // skid only ever holds the transaction behind a waiting one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held with output register empty");

  // column sums are written only for columns inside the output width
  a_wr_in_width: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (s1_addr_r < ow_c))
    else $error("column sum write beyond output width");

  // every result carries the alpha bit
  a_alpha_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0])
    else $error("result without alpha bit");

  // no pixel taken straight after a configuration write, as the block-grid counter rebuild begins
  a_no_take_resync: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_we) |-> !in_tready)
    else $error("input taken straight after a configuration write");
`endif

endmodule
